[sv/lpi_pkg.sv]
// Package for the Lorenz particle integrator: widths, constants, opcodes.
// Used by lpi_mulu, lpi_mem and the top level; depends on nothing.
`timescale 1ns / 1ps
package lpi_pkg;
  localparam int MAX_PARTICLES = 8192;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = IDX_W + 1;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FZ    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd6;

  localparam logic [31:0] LCG_MUL = 32'd214013;
  localparam logic [31:0] LCG_ADD = 32'd2531011;

  typedef struct packed {
    logic [31:0] px, py, pz, vx, vy, vz;
  } particle_t;

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v > 33'sd2147483647) r = 32'h7fffffff;
    else if (v < -33'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic [31:0] qsub(input logic [31:0] a, input logic [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction
endpackage

[sv/lorenz_particle_integrator.sv]
// Top level of the Lorenz particle integrator: sequencer, registers, handshake.
// Instantiates lpi_mulu and lpi_mem; depends on lpi_pkg.
`timescale 1ns / 1ps
// Each accepted item advances one particle and yields one result. An item
// passes through a state-memory read, three LCG draws on reseed frames,
// sixteen products through one shared registered multiplier, and a write-back.
// A result waits in an output register. The next item can be taken in the
// cycle after the result is delivered; no new item is taken while one is in
// flight or while its result waits, also while the receiver stalls. No
// clearing pass after reset.
module lorenz_particle_integrator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     in_frame_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpi_pkg::IDX_W-1:0]       out_particle_index,
  output logic signed [31:0]              out_pos_x,
  output logic signed [31:0]              out_pos_y,
  output logic signed [31:0]              out_pos_z,
  output logic                            out_last_in_frame,
  input  logic                            cfg_we,
  input  logic [lpi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpi_pkg::CFG_W-1:0]       cfg_data
);
  import lpi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LOAD, S_SEED, S_MUL, S_WAIT, S_WB, S_OUT
  } state_t;

  state_t state_r;
  logic [25:0] sigma_r;
  logic [26:0] rho_r;
  logic [23:0] beta_r;
  logic [31:0] fx_r, fy_r, fz_r;
  logic [CNT_W-1:0] count_r;
  logic [31:0] prev_time_r, delta_r, seed_r;
  logic reseed_frame_r, reseed_pend_r;
  logic [IDX_W-1:0] walk_r;
  logic [4:0] step_r;
  logic [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r;
  logic [31:0] rx_r, ry_r, rz_r, t0_r, t1_r, t2_r;
  logic [31:0] tmp_r;
  logic last_nxt;
  logic [CNT_W-1:0] count_eff;
  logic [32:0] ma, mb;
  logic [31:0] mq, seed_nxt, coord;
  logic [31:0] dyx, drz;
  logic cfg_count_we, frame_start, reseed_now;
  particle_t rd, wd;
  logic mem_we;

  lpi_mulu u_mul (.clk(clk), .a(ma), .b(mb), .q(mq));
  lpi_mem u_mem (.clk(clk), .we(mem_we), .addr(walk_r), .wdata(wd), .rdata(rd));

  always_comb begin
    if (count_r == '0) count_eff = CNT_W'(1);
    else if (count_r > CNT_W'(MAX_PARTICLES)) count_eff = CNT_W'(MAX_PARTICLES);
    else count_eff = count_r;
  end

  assign seed_nxt = seed_r * LCG_MUL + LCG_ADD;
  assign coord = {15'd0, seed_nxt[30:16], 2'b00} - 32'd65536;
  assign mem_we = (state_r == S_WB);
  assign wd = '{px: px_r, py: py_r, pz: pz_r, vx: vx_r, vy: vy_r, vz: vz_r};
  assign dyx = qsub(py_r, px_r);
  assign drz = qsub({5'd0, rho_r}, pz_r);
  assign last_nxt = ({1'b0, walk_r} + CNT_W'(1)) >= count_eff;
  assign cfg_count_we = cfg_we && (cfg_index == REG_COUNT);
  assign frame_start = (state_r == S_IDLE) && in_valid && (walk_r == '0);
  assign reseed_now = reseed_pend_r || (in_frame_time < prev_time_r);

  // operand select per multiply step
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_r)
      5'd0:  begin ma = {7'd0, sigma_r}; mb = {dyx[31], dyx}; end
      5'd1:  begin ma = {px_r[31], px_r}; mb = {drz[31], drz}; end
      5'd2:  begin ma = {px_r[31], px_r}; mb = {py_r[31], py_r}; end
      5'd3:  begin ma = {9'd0, beta_r}; mb = {pz_r[31], pz_r}; end
      5'd4:  begin ma = {ry_r[31], ry_r}; mb = {fz_r[31], fz_r}; end
      5'd5:  begin ma = {rz_r[31], rz_r}; mb = {fy_r[31], fy_r}; end
      5'd6:  begin ma = {rz_r[31], rz_r}; mb = {fx_r[31], fx_r}; end
      5'd7:  begin ma = {rx_r[31], rx_r}; mb = {fz_r[31], fz_r}; end
      5'd8:  begin ma = {rx_r[31], rx_r}; mb = {fy_r[31], fy_r}; end
      5'd9:  begin ma = {ry_r[31], ry_r}; mb = {fx_r[31], fx_r}; end
      5'd10: begin ma = {t0_r[31], t0_r}; mb = {1'b0, delta_r}; end
      5'd11: begin ma = {t1_r[31], t1_r}; mb = {1'b0, delta_r}; end
      5'd12: begin ma = {t2_r[31], t2_r}; mb = {1'b0, delta_r}; end
      5'd13: begin ma = {rx_r[31], rx_r}; mb = {1'b0, delta_r}; end
      5'd14: begin ma = {ry_r[31], ry_r}; mb = {1'b0, delta_r}; end
      5'd15: begin ma = {rz_r[31], rz_r}; mb = {1'b0, delta_r}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sigma_r <= 26'd655360;
      rho_r <= 27'd1835008;
      beta_r <= 24'd174763;
      fx_r <= '0;
      fy_r <= '0;
      fz_r <= '0;
      count_r <= CNT_W'(200);
      prev_time_r <= '0;
      delta_r <= '0;
      seed_r <= 32'd1;
      reseed_frame_r <= 1'b0;
      reseed_pend_r <= 1'b1;
      walk_r <= '0;
      step_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIGMA: sigma_r <= cfg_data[25:0];
          REG_RHO:   rho_r <= cfg_data[26:0];
          REG_BETA:  beta_r <= cfg_data[23:0];
          REG_FX:    fx_r <= cfg_data;
          REG_FY:    fy_r <= cfg_data;
          REG_FZ:    fz_r <= cfg_data;
          REG_COUNT: count_r <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_count_we) reseed_pend_r <= 1'b1;
      else if (frame_start && reseed_now) reseed_pend_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (walk_r == '0) begin
              if (reseed_now) begin
                reseed_frame_r <= 1'b1;
                delta_r <= '0;
              end else begin
                reseed_frame_r <= 1'b0;
                delta_r <= in_frame_time - prev_time_r;
              end
              prev_time_r <= in_frame_time;
            end
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_LOAD;
        S_LOAD: begin
          px_r <= rd.px; py_r <= rd.py; pz_r <= rd.pz;
          vx_r <= rd.vx; vy_r <= rd.vy; vz_r <= rd.vz;
          step_r <= '0;
          state_r <= reseed_frame_r ? S_SEED : S_MUL;
        end
        S_SEED: begin
          seed_r <= seed_nxt;
          unique case (step_r)
            5'd0: begin
              px_r <= coord;
              step_r <= 5'd1;
            end
            5'd1: begin
              py_r <= coord;
              step_r <= 5'd2;
            end
            default: begin
              pz_r <= coord;
              vx_r <= '0; vy_r <= '0; vz_r <= '0;
              step_r <= '0;
              state_r <= S_MUL;
            end
          endcase
        end
        S_MUL: state_r <= S_WAIT;
        S_WAIT: begin
          step_r <= step_r + 5'd1;
          state_r <= (step_r >= 5'd15) ? S_WB : S_MUL;
          unique case (step_r)
            5'd0: rx_r <= qadd(vx_r, mq);
            5'd1: tmp_r <= mq;
            5'd2: begin
              ry_r <= qadd(vy_r, qsub(tmp_r, py_r));
              tmp_r <= mq;
            end
            5'd3: rz_r <= qadd(vz_r, qsub(tmp_r, mq));
            5'd4: tmp_r <= mq;
            5'd5: t0_r <= qsub(tmp_r, mq);
            5'd6: tmp_r <= mq;
            5'd7: t1_r <= qsub(tmp_r, mq);
            5'd8: tmp_r <= mq;
            5'd9: t2_r <= qsub(tmp_r, mq);
            5'd10: vx_r <= qadd(vx_r, mq);
            5'd11: vy_r <= qadd(vy_r, mq);
            5'd12: vz_r <= qadd(vz_r, mq);
            5'd13: px_r <= qadd(px_r, mq);
            5'd14: py_r <= qadd(py_r, mq);
            default: pz_r <= qadd(pz_r, mq);
          endcase
        end
        S_WB: begin
          out_particle_index <= walk_r;
          out_pos_x <= px_r; out_pos_y <= py_r; out_pos_z <= pz_r;
          out_last_in_frame <= last_nxt;
          walk_r <= last_nxt ? '0 : walk_r + IDX_W'(1);
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

  ap_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("input taken while result pending");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  ap_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_in_frame |=> walk_r == '0)
    else $error("walk not rewound");
endmodule

[sv/lpi_mulu.sv]
// Shared Q16.16 multiplier: 33x33 signed product, floor shift by 16, saturate.
// Registered result; depends on lpi_pkg.
`timescale 1ns / 1ps
module lpi_mulu (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [32:0] b,
  output logic [31:0] q
);
  import lpi_pkg::*;
  logic signed [65:0] prod;
  logic signed [49:0] sh;
  logic [31:0] q_r;
  assign prod = $signed(a) * $signed(b);
  assign sh = prod[65:16];
  always_ff @(posedge clk) begin
    if (sh > 50'sd2147483647) q_r <= 32'h7fffffff;
    else if (sh < -50'sd2147483648) q_r <= 32'h80000000;
    else q_r <= sh[31:0];
  end
  assign q = q_r;
endmodule

[sv/lpi_mem.sv]
// Particle state memory: one row of position and velocity per particle.
// One write port, one registered read port; depends on lpi_pkg.
`timescale 1ns / 1ps
module lpi_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [lpi_pkg::IDX_W-1:0] addr,
  input  lpi_pkg::particle_t       wdata,
  output lpi_pkg::particle_t       rdata
);
  import lpi_pkg::*;
  particle_t mem [MAX_PARTICLES];
  particle_t rdata_r;
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end
  assign rdata = rdata_r;
endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for lorenz_particle_integrator: directed and random frames.
// Holds its own fixed-point particle predictor; depends on lpi_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import lpi_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] px, py, pz;
    logic               last;
  } particle_out_t;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_frame_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_particle_index;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_last_in_frame;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lorenz_particle_integrator u_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] sigma_q, rho_q, beta_q, count_q;
  logic signed [31:0] bfield_x, bfield_y, bfield_z;
  logic signed [31:0] st_px[MAX_PARTICLES], st_py[MAX_PARTICLES], st_pz[MAX_PARTICLES];
  logic signed [31:0] st_vx[MAX_PARTICLES], st_vy[MAX_PARTICLES], st_vz[MAX_PARTICLES];
  logic [31:0] prev_time, frame_dt, seed;
  logic reseed_now, reseed_req;
  int walk;

  logic [31:0] time_q[$];
  particle_out_t expected_q[$];
  int n_sent, n_checked, n_errors, n_reseeds, n_cfg;
  bit idle_on = 1'b1;
  int hold_req_n = 0;

  function automatic logic signed [31:0] sat(input logic signed [64:0] v);
    if (v > 65'sd2147483647) return 32'sh7fffffff;
    if (v < -65'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [64:0] p;
    p = $signed({{33{a[31]}}, a}) * $signed({{33{b[31]}}, b});
    return sat(p >>> 16);
  endfunction

  function automatic logic signed [31:0] qmulu(input logic signed [31:0] a,
                                               input logic [31:0] b);
    logic signed [64:0] p;
    p = $signed({{33{a[31]}}, a}) * $signed({33'b0, b});
    return sat(p >>> 16);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat($signed({{33{a[31]}}, a}) + $signed({{33{b[31]}}, b}));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat($signed({{33{a[31]}}, a}) - $signed({{33{b[31]}}, b}));
  endfunction

  function automatic logic signed [31:0] lcg_coord();
    seed = seed * LCG_MUL + LCG_ADD;
    return $signed({15'b0, seed[30:16], 2'b00}) - 32'sd65536;
  endfunction

  function automatic int live_count();
    if (count_q < 1) return 1;
    if (count_q > MAX_PARTICLES) return MAX_PARTICLES;
    return count_q;
  endfunction

  function automatic void model_reset();
    sigma_q = 655360; rho_q = 1835008; beta_q = 174763; count_q = 200;
    bfield_x = 0; bfield_y = 0; bfield_z = 0;
    prev_time = 0; frame_dt = 0; seed = 1; walk = 0;
    reseed_now = 1'b0; reseed_req = 1'b1;
    for (int k = 0; k < MAX_PARTICLES; k++) begin
      st_px[k] = 0; st_py[k] = 0; st_pz[k] = 0;
      st_vx[k] = 0; st_vy[k] = 0; st_vz[k] = 0;
    end
  endfunction

  function automatic void model_cfg(input logic [CFG_IDX_W-1:0] r, input logic [31:0] d);
    case (r)
      REG_SIGMA: sigma_q = {6'b0, d[25:0]};
      REG_RHO:   rho_q = {5'b0, d[26:0]};
      REG_BETA:  beta_q = {8'b0, d[23:0]};
      REG_FX:    bfield_x = d;
      REG_FY:    bfield_y = d;
      REG_FZ:    bfield_z = d;
      REG_COUNT: begin
        count_q = {18'b0, d[13:0]};
        reseed_req = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void advance_particle(input logic [31:0] t);
    int i, cnt;
    logic signed [31:0] px, py, pz, vx, vy, vz, rx, ry, rz, tx, ty, tz;
    particle_out_t e;
    cnt = live_count();
    if (walk == 0) begin
      if (reseed_req || t < prev_time) begin
        reseed_now = 1'b1;
        reseed_req = 1'b0;
        frame_dt = 0;
        n_reseeds++;
      end else begin
        reseed_now = 1'b0;
        frame_dt = t - prev_time;
      end
      prev_time = t;
    end
    i = walk;
    if (reseed_now) begin
      st_px[i] = lcg_coord();
      st_py[i] = lcg_coord();
      st_pz[i] = lcg_coord();
      st_vx[i] = 0; st_vy[i] = 0; st_vz[i] = 0;
    end
    px = st_px[i]; py = st_py[i]; pz = st_pz[i];
    vx = st_vx[i]; vy = st_vy[i]; vz = st_vz[i];
    rx = qadd(vx, qmul(sigma_q, qsub(py, px)));
    ry = qadd(vy, qsub(qmul(px, qsub(rho_q, pz)), py));
    rz = qadd(vz, qsub(qmul(px, py), qmul(beta_q, pz)));
    tx = qsub(qmul(ry, bfield_z), qmul(rz, bfield_y));
    ty = qsub(qmul(rz, bfield_x), qmul(rx, bfield_z));
    tz = qsub(qmul(rx, bfield_y), qmul(ry, bfield_x));
    st_vx[i] = qadd(vx, qmulu(tx, frame_dt));
    st_vy[i] = qadd(vy, qmulu(ty, frame_dt));
    st_vz[i] = qadd(vz, qmulu(tz, frame_dt));
    st_px[i] = qadd(px, qmulu(rx, frame_dt));
    st_py[i] = qadd(py, qmulu(ry, frame_dt));
    st_pz[i] = qadd(pz, qmulu(rz, frame_dt));
    e.idx = i[IDX_W-1:0];
    e.px = st_px[i]; e.py = st_py[i]; e.pz = st_pz[i];
    e.last = (i + 1 >= cnt);
    walk = e.last ? 0 : i + 1;
    expected_q.push_back(e);
  endfunction

  // driver
  int snd_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_particle(in_frame_time);
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (snd_gap > 0) begin
          snd_gap--;
          in_valid <= 1'b0;
        end else if (time_q.size() > 0) begin
          in_valid <= 1'b1;
          in_frame_time <= time_q.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0) snd_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rcv_gap = 0, hold_cnt = 0, hold_seen_n = 0;
  always @(posedge clk) begin
    particle_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result, index %0d", out_particle_index);
          n_errors++;
        end else begin
          e = expected_q.pop_front();
          n_checked++;
          if (out_particle_index !== e.idx) begin
            $error("particle_index exp %0d act %0d", e.idx, out_particle_index);
            n_errors++;
          end
          if (out_pos_x !== e.px) begin
            $error("pos_x exp %h act %h", e.px, out_pos_x);
            n_errors++;
          end
          if (out_pos_y !== e.py) begin
            $error("pos_y exp %h act %h", e.py, out_pos_y);
            n_errors++;
          end
          if (out_pos_z !== e.pz) begin
            $error("pos_z exp %h act %h", e.pz, out_pos_z);
            n_errors++;
          end
          if (out_last_in_frame !== e.last) begin
            $error("last_in_frame exp %0d act %0d", e.last, out_last_in_frame);
            n_errors++;
          end
        end
      end
      if (hold_seen_n != hold_req_n) begin
        hold_seen_n = hold_req_n;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) hold_cnt--;
      else if (rcv_gap > 0) rcv_gap--;
      else if (idle_on && $urandom_range(0, 9) == 0) rcv_gap = $urandom_range(1, 15);
      out_stall <= (hold_cnt > 0) || (rcv_gap > 0);
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus generation state
  int gen_walk = 0;
  logic [31:0] gen_count = 200;
  logic [31:0] gen_time = 0;

  function automatic int gen_live();
    if (gen_count < 1) return 1;
    if (gen_count > MAX_PARTICLES) return MAX_PARTICLES;
    return gen_count;
  endfunction

  function automatic void add_item(input logic [31:0] t);
    time_q.push_back(t);
    gen_walk = (gen_walk + 1 >= gen_live()) ? 0 : gen_walk + 1;
  endfunction

  function automatic void add_frame(input logic [31:0] t);
    add_item(t);
    while (gen_walk != 0) add_item($urandom);
  endfunction

  function automatic void add_random(input int n);
    logic [31:0] t;
    for (int k = 0; k < n; k++) begin
      if (gen_walk == 0) begin
        case ($urandom_range(0, 19))
          0: t = $urandom;
          1: t = gen_time - $urandom_range(1, 1000);
          2: t = gen_time;
          default: t = gen_time + $urandom_range(0, 32'h3000);
        endcase
        gen_time = t;
        add_item(t);
      end else begin
        add_item($urandom);
      end
    end
  endfunction

  task automatic drain();
    while (time_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] r, input logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    model_cfg(r, d);
    if (r == REG_COUNT) gen_count = {18'b0, d[13:0]};
    n_cfg++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int phase;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small frames, forward, equal and backward time
    cfg_write(REG_COUNT, 3);
    cfg_write(REG_FX, 32'h0001_0000);
    cfg_write(REG_FY, 32'h0000_8000);
    cfg_write(REG_FZ, 32'hffff_c000);
    add_frame(0);
    add_frame(32'h1000);
    add_frame(32'h1000);
    add_frame(32'h0800);
    drain();

    // extreme coefficients and field, count of zero, huge dt
    cfg_write(REG_SIGMA, 41943040);
    cfg_write(REG_RHO, 117440512);
    cfg_write(REG_BETA, 11184832);
    cfg_write(REG_FX, 32'h7fff_ffff);
    cfg_write(REG_FY, 32'h8000_0000);
    cfg_write(REG_FZ, 32'hffff_ffff);
    cfg_write(REG_COUNT, 0);
    add_frame(32'h0001_0000);
    add_frame(32'hffff_ffff);
    add_frame(32'hffff_ffff);
    add_frame(0);
    drain();

    // oversized count, then shrink mid-frame
    cfg_write(REG_SIGMA, 0);
    cfg_write(REG_RHO, 0);
    cfg_write(REG_BETA, 0);
    cfg_write(REG_COUNT, 16383);
    add_random(8);
    drain();
    cfg_write(REG_COUNT, 2);
    add_item(32'h10);
    add_frame(32'h20);
    drain();
    gen_time = 32'h20;

    for (phase = 0; n_sent + time_q.size() < 800; phase++) begin
      if (phase == 14) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_SIGMA, $urandom_range(0, 3) == 0 ? $urandom_range(0, 41943040)
                                                        : $urandom_range(0, 1310720));
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_RHO, $urandom_range(0, 3) == 0 ? $urandom_range(0, 117440512)
                                                      : $urandom_range(0, 3670016));
      if ($urandom_range(0, 2) == 0) cfg_write(REG_BETA, $urandom_range(0, 11184832));
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_FX, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2_0000));
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_FY, $urandom_range(0, 1) ? $urandom : 32'hfffe_0000 + $urandom_range(0, 32'h4_0000));
      if ($urandom_range(0, 2) == 0) cfg_write(REG_FZ, $urandom);
      if (gen_walk == 0 && $urandom_range(0, 3) == 0)
        cfg_write(REG_COUNT, $urandom_range(0, 4) == 0 ? $urandom_range(0, 40)
                                                        : $urandom_range(1, 12));
      add_random($urandom_range(10, 60));
      if (phase == 3) begin
        hold_req_n++;
        add_random(40);
      end
      drain();
    end
    repeat (100) @(posedge clk);
    $display("covered %0d particle steps, %0d checked, %0d register writes, %0d reseed frames",
             n_sent, n_checked, n_cfg, n_reseeds);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
